>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an expression on every clock edge
`define CHK_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// check a consequent in the same cycle as its antecedent
`define CHK_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequent in the cycle after its antecedent
`define CHK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lbcd_pkg.sv
// ----------------------------------------------------------------------------
// lbcd_pkg
// Sizes, controller/datapath interface types and helpers of the LFU directory.
// ----------------------------------------------------------------------------
package lbcd_pkg;

	localparam int SLOTS  = 16;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OCC_W  = $clog2(SLOTS + 1);
	localparam int FILE_W = 16;
	localparam int BLK_W  = 24;
	localparam int CNT_W  = 32;
	localparam int CAP_W  = 5;
	localparam int SLOT_W = 4;
	localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int SEL_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef struct packed {
		logic load_req;
		logic upd_hit;
		logic ins_free;
		logic scan_init;
		logic scan_step;
		logic ins_evict;
	} lbcd_cmd_t;

	typedef struct packed {
		logic hit;
		logic need_evict;
		logic scan_last;
	} lbcd_sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
	endfunction

endpackage

>>> rtl/lbcd_ctrl.sv
// ----------------------------------------------------------------------------
// lbcd_ctrl
// Request sequencer: lookup, optional victim scan, eviction and insert.
// ----------------------------------------------------------------------------
module lbcd_ctrl import lbcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  lbcd_sts_t sts,
	output logic      busy,
	output lbcd_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOOK  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_EVICT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (sts.hit) begin
					cmd.upd_hit = 1'b1;
					state_d     = ST_IDLE;
				end else if (sts.need_evict) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					cmd.ins_free = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.ins_evict = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/lbcd_datapath.sv
// ----------------------------------------------------------------------------
// lbcd_datapath
// Directory entries, tag match, occupancy, serial minimum-count scan and
// result register.
// ----------------------------------------------------------------------------
module lbcd_datapath import lbcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lbcd_cmd_t         cmd,
	output lbcd_sts_t         sts,
	input  logic [FILE_W-1:0] file_id,
	input  logic [BLK_W-1:0]  block_number,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,
	output logic              done,
	output logic              hit,
	output logic [SLOT_W-1:0] slot,
	output logic              evicted,
	output logic [FILE_W-1:0] evicted_file_id,
	output logic [BLK_W-1:0]  evicted_block_number,
	output logic [CNT_W-1:0]  use_count
);

	function automatic logic [IDX_W-1:0] first_zero(input logic [SLOTS-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [SEL_W-1:0] w;
		w = SEL_W'(idx);
		return w[SLOT_W-1:0];
	endfunction

	logic [FILE_W-1:0] req_file_q;
	logic [BLK_W-1:0]  req_blk_q;
	logic [CAP_W-1:0]  cap_q;
	logic [SLOTS-1:0]  valid_q;
	logic [OCC_W-1:0]  occ_q;
	logic [FILE_W-1:0] file_q [SLOTS];
	logic [BLK_W-1:0]  blk_q  [SLOTS];
	logic [CNT_W-1:0]  cnt_q  [SLOTS];

	logic [IDX_W-1:0]  scan_idx_q;
	logic              have_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [CNT_W-1:0]  best_cnt_q;
	logic [FILE_W-1:0] best_file_q;
	logic [BLK_W-1:0]  best_blk_q;

	logic              done_q;
	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic              evicted_q;
	logic [FILE_W-1:0] ev_file_q;
	logic [BLK_W-1:0]  ev_blk_q;
	logic [CNT_W-1:0]  use_q;

	logic [SLOTS-1:0]  match;
	logic              hit_any;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  free_idx;
	logic [SLOTS-1:0]  ev_mask;
	logic [IDX_W-1:0]  ev_free;
	logic [SLOTS-1:0]  valid_ev;
	logic [IDX_W-1:0]  wr_idx;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  eff_cap;
	logic [CMP_W-1:0]  occ_ext;
	logic [IDX_W-1:0]  rd_idx;
	logic [CNT_W-1:0]  rd_cnt;
	logic [CNT_W-1:0]  inc_cnt;
	logic              better;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (file_q[i] == req_file_q) && (blk_q[i] == req_blk_q);
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) hit_idx = IDX_W'(i);
		end
	end

	assign hit_any  = |match;
	assign free_idx = first_zero(valid_q);
	assign ev_mask  = valid_q & ~(SLOTS'(1) << best_idx_q);
	assign ev_free  = first_zero(ev_mask);
	assign valid_ev = ev_mask | (SLOTS'(1) << ev_free);
	assign wr_idx   = cmd.ins_evict ? ev_free : free_idx;

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		occ_ext = CMP_W'(occ_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(SLOTS)) begin
			eff_cap = CMP_W'(SLOTS);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign rd_idx  = cmd.scan_step ? scan_idx_q : hit_idx;
	assign rd_cnt  = cnt_q[rd_idx];
	assign inc_cnt = sat_inc(rd_cnt);
	assign better  = valid_q[scan_idx_q] && (!have_q || (rd_cnt < best_cnt_q));

	assign sts.hit        = hit_any;
	assign sts.need_evict = !hit_any && (occ_ext >= eff_cap);
	assign sts.scan_last  = (scan_idx_q == IDX_W'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_file_q <= file_id;
			req_blk_q  <= block_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.ins_free) begin
			valid_q[free_idx] <= 1'b1;
			occ_q             <= occ_q + OCC_W'(1);
		end else if (cmd.ins_evict) begin
			valid_q <= valid_ev;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_free || cmd.ins_evict) begin
			file_q[wr_idx] <= req_file_q;
			blk_q[wr_idx]  <= req_blk_q;
			cnt_q[wr_idx]  <= CNT_W'(1);
		end else if (cmd.upd_hit) begin
			cnt_q[hit_idx] <= inc_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			have_q     <= 1'b0;
		end else if (cmd.scan_init) begin
			scan_idx_q <= '0;
			have_q     <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (better) have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && better) begin
			best_idx_q  <= scan_idx_q;
			best_cnt_q  <= rd_cnt;
			best_file_q <= file_q[scan_idx_q];
			best_blk_q  <= blk_q[scan_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.upd_hit || cmd.ins_free || cmd.ins_evict;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_hit) begin
			hit_q     <= 1'b1;
			slot_q    <= to_slot(hit_idx);
			evicted_q <= 1'b0;
			ev_file_q <= '0;
			ev_blk_q  <= '0;
			use_q     <= inc_cnt;
		end else if (cmd.ins_free) begin
			hit_q     <= 1'b0;
			slot_q    <= to_slot(free_idx);
			evicted_q <= 1'b0;
			ev_file_q <= '0;
			ev_blk_q  <= '0;
			use_q     <= CNT_W'(1);
		end else if (cmd.ins_evict) begin
			hit_q     <= 1'b0;
			slot_q    <= to_slot(ev_free);
			evicted_q <= have_q;
			ev_file_q <= have_q ? best_file_q : '0;
			ev_blk_q  <= have_q ? best_blk_q : '0;
			use_q     <= CNT_W'(1);
		end
	end

	assign done                 = done_q;
	assign hit                  = hit_q;
	assign slot                 = slot_q;
	assign evicted              = evicted_q;
	assign evicted_file_id      = ev_file_q;
	assign evicted_block_number = ev_blk_q;
	assign use_count            = use_q;

endmodule

>>> rtl/lfu_block_cache_directory_core.sv
// ----------------------------------------------------------------------------
// lfu_block_cache_directory_core
// Tag directory of a fully associative block cache with LFU replacement.
//
//   channel   handshake          payload
//   request   start / busy       file_id, block_number
//   result    done (one cycle)   hit, slot, evicted, evicted_file_id,
//                                evicted_block_number, use_count
//   config    cfg_we             cfg_wdata (capacity_in_use)
//
// A hit or a miss with a free slot goes through the lookup state, which registers
// done; busy is already low while done is shown, so a new request can be taken.
// A miss at capacity runs a serial minimum-count scan, one slot per cycle,
// over all SLOTS slots, then evicts and inserts before done rises.
// Reset empties the directory and sets the capacity to 16.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module lfu_block_cache_directory_core import lbcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [FILE_W-1:0] file_id,
	input  logic [BLK_W-1:0]  block_number,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,
	output logic              done,
	output logic              hit,
	output logic [SLOT_W-1:0] slot,
	output logic              evicted,
	output logic [FILE_W-1:0] evicted_file_id,
	output logic [BLK_W-1:0]  evicted_block_number,
	output logic [CNT_W-1:0]  use_count
);

	lbcd_cmd_t cmd;
	lbcd_sts_t sts;

	lbcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	lbcd_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.file_id              (file_id),
		.block_number         (block_number),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.done                 (done),
		.hit                  (hit),
		.slot                 (slot),
		.evicted              (evicted),
		.evicted_file_id      (evicted_file_id),
		.evicted_block_number (evicted_block_number),
		.use_count            (use_count)
	);

endmodule

>>> rtl/lbcd_checker.sv
// ----------------------------------------------------------------------------
// lbcd_checker
// Port-level checks of the LFU directory, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbcd_checker import lbcd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              hit,
	input logic              evicted,
	input logic [FILE_W-1:0] evicted_file_id,
	input logic [BLK_W-1:0]  evicted_block_number,
	input logic [CNT_W-1:0]  use_count
);

	`CHK_NEXT(a_accept_busy, start && !busy, busy && !done, "transfer did not raise busy")
	`CHK_SAME(a_done_idle, done, !busy, "result shown while busy")
	`CHK_SAME(a_hit_no_evict, done && hit, !evicted, "hit reported an eviction")
	`CHK_SAME(a_miss_count, done && !hit, use_count == CNT_W'(1), "inserted count not one")
	`CHK_SAME(a_evict_zero, done && !evicted,
		(evicted_file_id == '0) && (evicted_block_number == '0), "stale evicted tag")

endmodule

bind lfu_block_cache_directory_core lbcd_checker u_lbcd_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.start                (start),
	.busy                 (busy),
	.done                 (done),
	.hit                  (hit),
	.evicted              (evicted),
	.evicted_file_id      (evicted_file_id),
	.evicted_block_number (evicted_block_number),
	.use_count            (use_count)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookups into the LFU block cache directory and checks each result
// against a behavioral mirror of the tag directory: hit detection, slot choice,
// lowest-count eviction with ties to the lowest slot, and use counts. The
// capacity register is rewritten between phases, including out-of-range and
// below-occupancy values, while requests come with random gaps in all but one phase.
// ----------------------------------------------------------------------------
module testbench;
	import lbcd_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int SETTLE      = SLOTS + 8;
	localparam int WATCHDOG    = 4000;
	localparam int POOL_MAX    = 40;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [FILE_W-1:0] ev_file;
		logic [BLK_W-1:0]  ev_block;
		logic [CNT_W-1:0]  count;
	} lookup_t;

	class directory_mirror;
		logic              live  [SLOTS];
		logic [FILE_W-1:0] owner [SLOTS];
		logic [BLK_W-1:0]  tag   [SLOTS];
		logic [CNT_W-1:0]  uses  [SLOTS];
		logic [CAP_W-1:0]  capacity;
		lookup_t           awaited [$];
		int unsigned       mismatches;

		function new();
			foreach (live[i]) begin
				live[i]  = 1'b0;
				owner[i] = '0;
				tag[i]   = '0;
				uses[i]  = '0;
			end
			capacity   = CAP_RESET;
			mismatches = 0;
		endfunction

		function void set_capacity(input logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(input logic [FILE_W-1:0] f, input logic [BLK_W-1:0] b);
			int      limit;
			int      used;
			int      pick;
			int      victim;
			bit      found;
			bit      have;
			lookup_t r;
			limit  = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
			used   = 0;
			pick   = 0;
			victim = 0;
			found  = 1'b0;
			have   = 1'b0;
			r      = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (live[i]) begin
					used++;
					if (!found && owner[i] == f && tag[i] == b) begin
						found = 1'b1;
						pick  = i;
					end
				end
			end
			if (found) begin
				if (uses[pick] != '1)
					uses[pick] = uses[pick] + CNT_W'(1);
			end else begin
				if (used >= limit) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (live[i] && (!have || uses[i] < uses[victim])) begin
							victim = i;
							have   = 1'b1;
						end
					end
					if (have) begin
						r.evicted    = 1'b1;
						r.ev_file    = owner[victim];
						r.ev_block   = tag[victim];
						live[victim] = 1'b0;
					end
				end
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!live[i])
						pick = i;
				live[pick]  = 1'b1;
				owner[pick] = f;
				tag[pick]   = b;
				uses[pick]  = CNT_W'(1);
			end
			r.hit   = found;
			r.slot  = SLOT_W'(pick);
			r.count = uses[pick];
			awaited = {awaited, r};
		endfunction

		function void compare(input string field, input logic [CNT_W-1:0] want,
				input logic [CNT_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(input lookup_t got);
			lookup_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual slot %0h count %0h",
					$time, got.slot, got.count);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			compare("hit", CNT_W'(want.hit), CNT_W'(got.hit));
			compare("slot", CNT_W'(want.slot), CNT_W'(got.slot));
			compare("evicted", CNT_W'(want.evicted), CNT_W'(got.evicted));
			compare("evicted_file_id", CNT_W'(want.ev_file), CNT_W'(got.ev_file));
			compare("evicted_block_number", CNT_W'(want.ev_block), CNT_W'(got.ev_block));
			compare("use_count", want.count, got.count);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [FILE_W-1:0] file_id;
	logic [BLK_W-1:0]  block_number;
	logic              cfg_we;
	logic [CAP_W-1:0]  cfg_wdata;
	logic              done;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              evicted;
	logic [FILE_W-1:0] evicted_file_id;
	logic [BLK_W-1:0]  evicted_block_number;
	logic [CNT_W-1:0]  use_count;

	directory_mirror   mirror;
	bit                gaps_on;
	int unsigned       quiet;
	logic [FILE_W-1:0] pool_file [POOL_MAX];
	logic [BLK_W-1:0]  pool_blk  [POOL_MAX];

	lfu_block_cache_directory_core dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.file_id              (file_id),
		.block_number         (block_number),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.done                 (done),
		.hit                  (hit),
		.slot                 (slot),
		.evicted              (evicted),
		.evicted_file_id      (evicted_file_id),
		.evicted_block_number (evicted_block_number),
		.use_count            (use_count)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_result(lookup_t'({hit, slot, evicted, evicted_file_id,
					evicted_block_number, use_count}));
			if (cfg_we)
				mirror.set_capacity(cfg_wdata);
			if (start && !busy)
				mirror.note_request(file_id, block_number);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("** lfu_block_cache_directory_core: FAILED **");
			$finish;
		end
	end

	task automatic issue(input logic [FILE_W-1:0] f, input logic [BLK_W-1:0] b);
		if (gaps_on)
			while ($urandom_range(0, 99) < 34) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start        <= 1'b1;
		file_id      <= f;
		block_number <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input int items, input int keys);
		int                k;
		int                roll;
		logic [FILE_W-1:0] f;
		logic [BLK_W-1:0]  b;
		for (int i = 0; i < keys; i++) begin
			pool_file[i] = (i > 0 && $urandom_range(0, 3) == 0) ? pool_file[i-1] : FILE_W'($urandom);
			pool_blk[i]  = (i > 0 && $urandom_range(0, 3) == 0) ? pool_blk[i-1] : BLK_W'($urandom);
		end
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				k = $urandom_range(0, $urandom_range(0, keys - 1));
				f = pool_file[k];
				b = pool_blk[k];
			end else begin
				f = FILE_W'($urandom);
				b = BLK_W'($urandom);
			end
			issue(f, b);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps [8];
		int               eff;
		caps         = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd31, 5'd0, 5'd12, 5'd16};
		arst_n       = 1'b0;
		start        = 1'b0;
		file_id      = '0;
		block_number = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		gaps_on      = 1'b1;
		mirror       = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue('0, '0);
		issue('0, '0);
		issue('1, '1);
		issue('1, '1);
		issue('0, '1);
		issue('1, '0);
		issue(16'h5555, 24'hAAAAAA);
		issue(16'hAAAA, 24'h555555);
		// shrink below occupancy
		write_capacity(5'd2);
		issue(16'h0001, 24'h000001);
		issue(16'h0001, 24'h000001);
		issue(16'h0002, 24'h000002);
		write_capacity(5'd0);
		issue(16'h0003, 24'h000003);
		issue('0, '0);
		write_capacity(5'd1);
		issue(16'h0004, 24'h000004);
		write_capacity(5'd31);
		for (int i = 0; i < 10; i++)
			issue(16'h8000 | FILE_W'(i), 24'h800000 | BLK_W'(i));

		foreach (caps[p]) begin
			if (p == 7)
				caps[p] = CAP_W'($urandom_range(0, 31));
			write_capacity(caps[p]);
			eff     = (caps[p] == 0) ? 1 : (caps[p] > SLOTS) ? SLOTS : int'(caps[p]);
			gaps_on = (p != 3);
			run_phase(50, eff + 4 + $urandom_range(0, 4));
		end

		drain();
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("** lfu_block_cache_directory_core: PASSED **");
		else
			$display("** lfu_block_cache_directory_core: FAILED **");
		$finish;
	end

endmodule
